// ===== design/wdvm_pkg.sv =====
package wdvm_pkg;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_TRIGGER = 2'd1;
  localparam logic [1:0] ACT_VOICE   = 2'd2;
  localparam logic [1:0] ACT_TABLE   = 2'd3;

  localparam logic [1:0] CFG_SOLO    = 2'd0;
  localparam logic [1:0] CFG_RUNNING = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;

  localparam logic [15:0] ENV_PHASE_RST = 16'h8000;
  localparam logic [7:0]  SAMPLE_BIAS   = 8'd127;
  localparam logic [10:0] MOD_CENTER    = 11'd512;
  // ceil(2^17 / 3), exact floor(n / 3) for any 16-bit n
  localparam logic [15:0] RECIP_THIRD   = 16'd43691;

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  trigger_mask;
    logic [2:0]  voice;
    logic [11:0] wave_base;
    logic [11:0] env_base;
    logic [15:0] env_increment;
    logic [15:0] pitch;
    logic [9:0]  pitch_mod;
    logic [11:0] table_addr;
    logic [7:0]  table_data;
  } in_t;

  typedef struct packed {
    logic [7:0] sample;
    logic       step_pulse;
  } out_t;

  typedef struct packed {
    logic [15:0] env_phase;
    logic [15:0] env_step;
    logic [7:0]  amp_level;
    logic [15:0] wave_phase;
    logic [15:0] wave_step;
    logic [15:0] base_pitch;
    logic [9:0]  mod_depth;
    logic [11:0] wave_addr;
    logic [11:0] env_addr;
  } voice_t;

  localparam voice_t VOICE_RST = '{
    env_phase:  ENV_PHASE_RST,
    env_step:   16'd10,
    amp_level:  8'd255,
    wave_phase: 16'd0,
    wave_step:  16'd1000,
    base_pitch: 16'd500,
    mod_depth:  10'd0,
    wave_addr:  12'd0,
    env_addr:   12'd0
  };

endpackage

// ===== design/wavetable_drum_voice_mixer.sv =====
// channel   direction  ports                               transfer when
// in        input      in_valid, in_stall, in_data         in_valid && !in_stall
// out       output     out_valid, out_stall, out_data      out_valid && !out_stall
// cfg       input      cfg_wr_en, cfg_index, cfg_data      cfg_wr_en
//
// a tick visits the voices in turn through the voice memory; a soloed voice gets read,
// envelope table read, amplitude load on an envelope tick, two multiply steps (second
// on a pitch tick only), write back with wave table read, accumulate if amplitude is
// not zero; an unsoloed voice is only read; then finish, direct if not running; a
// trigger reads each voice and writes back masked ones; synchronous active-low reset,
// input stalled while in reset; no clearing pass, voice memory entries carry valid bits
// a stalled result holds the finished tick in its last state; other actions keep moving
module wavetable_drum_voice_mixer
  import wdvm_pkg::*;
#(
  parameter int NUM_VOICES      = 8,
  parameter int TABLE_ADDR_BITS = 12,
  parameter int AMP_DIVIDER     = 7,
  parameter int PITCH_DIVIDER   = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  localparam int AW = TABLE_ADDR_BITS;
  localparam int TDEPTH = 1 << AW;
  localparam logic [VW-1:0] LAST_V = VW'(NUM_VOICES - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_VRD  = 4'd1;
  localparam logic [3:0] S_ENV  = 4'd2;
  localparam logic [3:0] S_AMP  = 4'd3;
  localparam logic [3:0] S_MUL1 = 4'd4;
  localparam logic [3:0] S_MUL2 = 4'd5;
  localparam logic [3:0] S_WAV  = 4'd6;
  localparam logic [3:0] S_TRM  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;
  localparam logic [3:0] S_TRD  = 4'd9;
  localparam logic [3:0] S_TWR  = 4'd10;
  localparam logic [3:0] S_SRD  = 4'd11;
  localparam logic [3:0] S_SWR  = 4'd12;

  logic [3:0]  state_r, state_nxt;
  logic [VW-1:0] vi_r, vi_nxt;
  in_t         in_r;
  voice_t      cur_r, cur_nxt;
  logic [7:0]  acc_r, acc_nxt;
  logic        env_tick_r, pitch_tick_r, pulse_r;
  logic [31:0] prod1_r;
  logic signed [43:0] prod2_r;

  logic [7:0]  solo_r;
  logic        running_r;
  logic [15:0] period_r;
  logic [15:0] third_r;

  logic [7:0]  amp_div_r;
  logic [15:0] pitch_div_r;
  logic [15:0] step_cnt_r;
  logic [7:0]  last_sample_r;
  logic        out_valid_r;
  out_t        out_r;

  voice_t      vmem [NUM_VOICES];
  logic [NUM_VOICES-1:0] vld_r;
  voice_t      rd_q;
  logic        vld_q;
  voice_t      vq;
  logic        vwr_en;
  voice_t      vwr_data;

  logic [7:0]  tmem [TDEPTH];
  logic [7:0]  tbl_q;
  logic [AW-1:0] tbl_raddr;
  logic        tbl_wr;
  logic [AW-1:0] tbl_waddr;

  logic        in_xfer, slot_free;
  logic [27:0] env_sum, wav_sum, twr_sum;
  logic [15:0] new_step, new_phase;
  logic signed [16:0] term;
  logic signed [10:0] mod_s;
  logic [15:0] q2, q4, q23, q34;
  logic [31:0] third_prod;
  logic        step_hit;

  function automatic logic [8:0] env_nph_v(input voice_t v);
    logic [15:0] s;
    s = v.env_phase + v.env_step;
    return s[15:7];
  endfunction

  assign in_xfer   = in_valid && !in_stall;
  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign vq = vld_q ? rd_q : VOICE_RST;

  assign env_sum = 28'(vq.env_addr) + 28'(env_nph_v(vq));

  assign new_step  = pitch_tick_r ? 16'(cur_r.base_pitch + prod2_r[37:22]) : cur_r.wave_step;
  assign new_phase = cur_r.wave_phase + new_step;
  assign wav_sum   = 28'(cur_r.wave_addr) + 28'(new_phase[15:8]);
  assign twr_sum   = 28'(in_data.table_addr);
  assign term      = $signed(tbl_q) * $signed({1'b0, cur_r.amp_level});
  assign mod_s     = $signed({1'b0, cur_r.mod_depth}) - $signed(MOD_CENTER);

  assign third_prod = 32'(cfg_data) * 32'(RECIP_THIRD);
  assign q2  = {1'b0, period_r[15:1]};
  assign q4  = {2'b0, period_r[15:2]};
  assign q23 = {third_r[14:0], 1'b0};
  assign q34 = 16'(q4 + {q4[14:0], 1'b0});
  assign step_hit = (step_cnt_r == q4) || (step_cnt_r == third_r) || (step_cnt_r == q2) ||
                    (step_cnt_r == q23) || (step_cnt_r == q34);

  always_comb begin
    state_nxt = state_r;
    vi_nxt    = vi_r;
    cur_nxt   = cur_r;
    acc_nxt   = acc_r;
    vwr_en    = 1'b0;
    vwr_data  = vq;
    tbl_raddr = wav_sum[AW-1:0];
    tbl_wr    = 1'b0;
    tbl_waddr = twr_sum[AW-1:0];
    case (state_r)
      S_IDLE: begin
        vi_nxt = '0;
        if (in_xfer) begin
          case (in_data.action)
            ACT_TICK: begin
              acc_nxt   = SAMPLE_BIAS;
              state_nxt = running_r ? S_VRD : S_FIN;
            end
            ACT_TRIGGER: state_nxt = S_TRD;
            ACT_VOICE: begin
              if (32'(in_data.voice) < NUM_VOICES) begin
                vi_nxt    = VW'(in_data.voice);
                state_nxt = S_SRD;
              end
            end
            ACT_TABLE: tbl_wr = 1'b1;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_VRD: begin
        if (solo_r[vi_r]) begin
          state_nxt = S_ENV;
        end else if (vi_r == LAST_V) begin
          state_nxt = S_FIN;
        end else begin
          vi_nxt = vi_r + 1'b1;
        end
      end
      S_ENV: begin
        cur_nxt   = vq;
        tbl_raddr = env_sum[AW-1:0];
        state_nxt = S_MUL1;
        if (env_tick_r) begin
          if (!vq.env_phase[15]) begin
            cur_nxt.env_phase = 16'(vq.env_phase + vq.env_step);
            state_nxt = S_AMP;
          end else begin
            cur_nxt.amp_level = 8'd0;
          end
        end
      end
      S_AMP: begin
        cur_nxt.amp_level = cur_r.env_phase[15] ? 8'd0 : tbl_q;
        state_nxt = S_MUL1;
      end
      S_MUL1: state_nxt = pitch_tick_r ? S_MUL2 : S_WAV;
      S_MUL2: state_nxt = S_WAV;
      S_WAV: begin
        vwr_en              = 1'b1;
        vwr_data            = cur_r;
        vwr_data.wave_step  = new_step;
        vwr_data.wave_phase = new_phase;
        if (cur_r.amp_level != 8'd0) begin
          state_nxt = S_TRM;
        end else if (vi_r == LAST_V) begin
          state_nxt = S_FIN;
        end else begin
          vi_nxt    = vi_r + 1'b1;
          state_nxt = S_VRD;
        end
      end
      S_TRM: begin
        acc_nxt = acc_r + term[15:8];
        if (vi_r == LAST_V) begin
          state_nxt = S_FIN;
        end else begin
          vi_nxt    = vi_r + 1'b1;
          state_nxt = S_VRD;
        end
      end
      S_FIN: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_TRD: begin
        if (in_r.trigger_mask[vi_r]) begin
          state_nxt = S_TWR;
        end else if (vi_r == LAST_V) begin
          state_nxt = S_IDLE;
        end else begin
          vi_nxt = vi_r + 1'b1;
        end
      end
      S_TWR: begin
        vwr_en             = 1'b1;
        vwr_data.env_phase = 16'd0;
        if (vi_r == LAST_V) begin
          state_nxt = S_IDLE;
        end else begin
          vi_nxt    = vi_r + 1'b1;
          state_nxt = S_TRD;
        end
      end
      S_SRD: state_nxt = S_SWR;
      S_SWR: begin
        vwr_en              = 1'b1;
        vwr_data.wave_addr  = in_r.wave_base;
        vwr_data.env_addr   = in_r.env_base;
        vwr_data.env_step   = in_r.env_increment;
        vwr_data.base_pitch = in_r.pitch;
        vwr_data.mod_depth  = in_r.pitch_mod;
        state_nxt           = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // voice memory and wave table
  always_ff @(posedge clk) begin
    if (vwr_en) vmem[vi_r] <= vwr_data;
    rd_q <= vmem[vi_nxt];
    if (tbl_wr) tmem[tbl_waddr] <= in_data.table_data;
    tbl_q <= tmem[tbl_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      vld_q <= 1'b0;
    end else begin
      if (vwr_en) vld_r[vi_r] <= 1'b1;
      vld_q <= (vwr_en && vi_r == vi_nxt) ? 1'b1 : vld_r[vi_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) in_r <= in_data;
    cur_r   <= cur_nxt;
    acc_r   <= acc_nxt;
    prod1_r <= 32'(cur_r.base_pitch) * 32'(cur_r.env_phase);
    prod2_r <= $signed({1'b0, prod1_r}) * mod_s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      vi_r          <= '0;
      solo_r        <= 8'd255;
      running_r     <= 1'b1;
      period_r      <= 16'd4000;
      third_r       <= 16'd4000 / 16'd3;
      amp_div_r     <= 8'(AMP_DIVIDER);
      pitch_div_r   <= 16'(PITCH_DIVIDER);
      step_cnt_r    <= 16'd0;
      last_sample_r <= 8'd0;
      env_tick_r    <= 1'b0;
      pitch_tick_r  <= 1'b0;
      pulse_r       <= 1'b0;
      out_valid_r   <= 1'b0;
      out_r         <= '0;
    end else begin
      state_r <= state_nxt;
      vi_r    <= vi_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SOLO:    solo_r    <= cfg_data[7:0];
          CFG_RUNNING: running_r <= cfg_data[0];
          CFG_PERIOD: begin
            period_r <= cfg_data;
            third_r  <= {1'b0, third_prod[31:17]};
          end
          default:     solo_r    <= solo_r;
        endcase
      end
      if (state_r == S_IDLE && in_xfer && in_data.action == ACT_TICK) begin
        env_tick_r   <= (amp_div_r == 8'd0);
        amp_div_r    <= (amp_div_r == 8'd0) ? 8'(AMP_DIVIDER) : amp_div_r - 1'b1;
        pitch_tick_r <= (pitch_div_r == 16'd0);
        pitch_div_r  <= (pitch_div_r == 16'd0) ? 16'(PITCH_DIVIDER) : pitch_div_r - 1'b1;
        pulse_r      <= (step_cnt_r == 16'd0) || step_hit;
        step_cnt_r   <= (step_cnt_r == 16'd0) ? period_r - 1'b1 : step_cnt_r - 1'b1;
      end
      if (state_r == S_FIN && slot_free) begin
        out_valid_r <= 1'b1;
        out_r.sample     <= running_r ? acc_r : last_sample_r;
        out_r.step_pulse <= pulse_r;
        if (running_r) last_sample_r <= acc_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

// ===== test/tb.sv =====
module tb;
  import wdvm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NV = 8;
  localparam int TICK_LATENCY = 80;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TABLE_WINDOW = 512;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  wavetable_drum_voice_mixer u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b0; #6;
    clk = 1'b1; #6;
  end

  // mirror of the mixer state
  bit [7:0]  wave_table [4096];
  bit [15:0] m_env_phase [NV];
  bit [15:0] m_env_step [NV];
  bit [7:0]  m_amp [NV];
  bit [15:0] m_wave_phase [NV];
  bit [15:0] m_wave_step [NV];
  bit [15:0] m_base_pitch [NV];
  bit [9:0]  m_mod_depth [NV];
  bit [11:0] m_wave_addr [NV];
  bit [11:0] m_env_addr [NV];
  bit [15:0] m_step_count;
  bit [7:0]  m_amp_div;
  bit [15:0] m_pitch_div;
  bit [7:0]  m_last_sample;
  bit [7:0]  m_solo;
  bit        m_running;
  bit [15:0] m_period;

  out_t expected_samples[$];
  int   errors;
  int   mismatches;
  bit   no_idle;
  int   stall_left = 0;
  int   quiet_cycles = 0;

  function automatic int voice_contribution(int v, bit env_tick, bit pitch_tick);
    longint prod;
    longint delta;
    bit [7:0] raw;
    int p;
    if (env_tick) begin
      if (!m_env_phase[v][15]) begin
        m_env_phase[v] = m_env_phase[v] + m_env_step[v];
        m_amp[v] = wave_table[12'(m_env_addr[v] + (m_env_phase[v] >> 7))];
        if (m_env_phase[v][15]) m_amp[v] = 0;
      end else begin
        m_amp[v] = 0;
      end
    end
    if (pitch_tick) begin
      prod = longint'(m_base_pitch[v]) * longint'(m_env_phase[v])
             * (longint'(m_mod_depth[v]) - 512);
      delta = prod >>> 22;
      m_wave_step[v] = 16'(longint'(m_base_pitch[v]) + delta);
    end
    m_wave_phase[v] = m_wave_phase[v] + m_wave_step[v];
    if (m_amp[v] == 0) return 0;
    raw = wave_table[12'(m_wave_addr[v] + (m_wave_phase[v] >> 8))];
    p = int'($signed(raw)) * int'(m_amp[v]);
    return p >>> 8;
  endfunction

  function automatic void predict_item(in_t d);
    bit env_tick;
    bit pitch_tick;
    bit pulse;
    bit [7:0] acc;
    bit [15:0] p;
    out_t r;
    case (d.action)
      ACT_TRIGGER: begin
        for (int v = 0; v < NV; v++) if (d.trigger_mask[v]) m_env_phase[v] = 0;
      end
      ACT_VOICE: begin
        m_wave_addr[d.voice] = d.wave_base;
        m_env_addr[d.voice] = d.env_base;
        m_env_step[d.voice] = d.env_increment;
        m_base_pitch[d.voice] = d.pitch;
        m_mod_depth[d.voice] = d.pitch_mod;
      end
      ACT_TABLE: wave_table[d.table_addr] = d.table_data;
      default: begin
        p = m_period;
        env_tick = (m_amp_div == 0);
        m_amp_div = env_tick ? 8'd7 : m_amp_div - 8'd1;
        pitch_tick = (m_pitch_div == 0);
        m_pitch_div = pitch_tick ? 16'd15 : m_pitch_div - 16'd1;
        if (m_running) begin
          acc = 8'd127;
          for (int v = 0; v < NV; v++)
            if (m_solo[v]) acc = acc + 8'(voice_contribution(v, env_tick, pitch_tick));
          m_last_sample = acc;
        end
        pulse = 0;
        if (m_step_count == 0) begin
          m_step_count = p;
          pulse = 1;
        end else if (m_step_count == p / 4 || m_step_count == p / 3 ||
                     m_step_count == p / 2 || m_step_count == 16'(2 * (p / 3)) ||
                     m_step_count == 16'(3 * (p / 4))) begin
          pulse = 1;
        end
        m_step_count = m_step_count - 16'd1;
        r.sample = m_last_sample;
        r.step_pulse = pulse;
        expected_samples.push_back(r);
      end
    endcase
  endfunction

  // result checker and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("** wavetable_drum_voice_mixer: FAILED **");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          errors++;
          if (mismatches++ < 10) $display("unexpected result %p", out_data);
        end else begin
          out_t e;
          e = expected_samples.pop_front();
          if (e.sample !== out_data.sample || e.step_pulse !== out_data.step_pulse) begin
            errors++;
            if (mismatches++ < 10)
              $display("mismatch: expected sample %0d pulse %0d, got sample %0d pulse %0d",
                       e.sample, e.step_pulse, out_data.sample, out_data.step_pulse);
          end
        end
      end
    end
  end

  // receiver backpressure
  always @(negedge clk) begin
    if (no_idle || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(99) < 10) stall_left <= $urandom_range(3, 1);
      else if ($urandom_range(99) < 2) stall_left <= $urandom_range(40, 20);
    end
  end

  task automatic send_item(in_t d);
    int gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(99) < 30) gap = $urandom_range(3, 1);
      else if ($urandom_range(99) < 4) gap = $urandom_range(40, 10);
    end
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data = d;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    predict_item(d);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (TICK_LATENCY) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    case (idx)
      CFG_SOLO: m_solo = val[7:0];
      CFG_RUNNING: m_running = val[0];
      default: m_period = val;
    endcase
  endtask

  // voice bases stay inside the filled table window
  function automatic in_t random_fields(logic [1:0] act);
    in_t d;
    d.action = act;
    d.trigger_mask = 8'($urandom);
    d.voice = 3'($urandom);
    d.wave_base = 12'($urandom_range(TABLE_WINDOW - 256));
    d.env_base = 12'd0;
    d.env_increment = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(600));
    d.pitch = 16'($urandom);
    d.pitch_mod = 10'($urandom);
    d.table_addr = 12'($urandom);
    d.table_data = 8'($urandom);
    return d;
  endfunction

  task automatic send_tick();
    send_item(random_fields(ACT_TICK));
  endtask

  task automatic send_voice(int v, logic [11:0] wb, logic [11:0] eb, logic [15:0] inc,
                            logic [15:0] pit, logic [9:0] md);
    in_t d;
    d = random_fields(ACT_VOICE);
    d.voice = 3'(v);
    d.wave_base = wb;
    d.env_base = eb;
    d.env_increment = inc;
    d.pitch = pit;
    d.pitch_mod = md;
    send_item(d);
  endtask

  task automatic send_trigger(logic [7:0] mask);
    in_t d;
    d = random_fields(ACT_TRIGGER);
    d.trigger_mask = mask;
    send_item(d);
  endtask

  // every table byte a tick can read is written before the first tick
  task automatic test_table_fill();
    in_t d;
    no_idle = 1;
    for (int a = 0; a < TABLE_WINDOW; a++) begin
      d = random_fields(ACT_TABLE);
      d.table_addr = 12'(a);
      d.table_data = (a % 97 == 0) ? 8'h80 : (a % 89 == 0) ? 8'h7f : 8'($urandom);
      send_item(d);
    end
    no_idle = 0;
  endtask

  task automatic test_directed();
    send_tick();
    send_tick();
    send_voice(0, 12'd256, 12'h000, 16'hffff, 16'hffff, 10'd1023);
    send_voice(1, 12'h000, 12'h000, 16'h0000, 16'h0000, 10'd0);
    send_voice(2, 12'd128, 12'h000, 16'd200, 16'd3000, 10'd512);
    send_voice(7, 12'd255, 12'h000, 16'd50, 16'd65535, 10'd0);
    send_trigger(8'hff);
    for (int i = 0; i < 10; i++) send_tick();
    send_trigger(8'h00);
    send_trigger(8'h81);
    for (int i = 0; i < 5; i++) send_tick();
  endtask

  task automatic test_config_extremes();
    wait_idle();
    write_reg(CFG_RUNNING, 16'd0);
    write_reg(CFG_PERIOD, 16'd0);
    for (int i = 0; i < 6; i++) send_tick();
    wait_idle();
    write_reg(CFG_RUNNING, 16'd1);
    write_reg(CFG_SOLO, 16'd0);
    write_reg(CFG_PERIOD, 16'd1);
    for (int i = 0; i < 4; i++) send_tick();
    wait_idle();
    write_reg(CFG_SOLO, 16'h00ff);
    write_reg(CFG_PERIOD, 16'hffff);
    for (int i = 0; i < 4; i++) send_tick();
  endtask

  task automatic test_random();
    int r;
    logic [15:0] periods [6] = '{16'd0, 16'd2, 16'd12, 16'd37, 16'd65535, 16'd4000};
    for (int phase = 0; phase < 6; phase++) begin
      wait_idle();
      write_reg(CFG_SOLO, (phase == 5) ? 16'h00ff : 16'($urandom_range(255)));
      write_reg(CFG_RUNNING, (phase == 2) ? 16'd0 : 16'd1);
      write_reg(CFG_PERIOD, periods[phase] == 16'd4000 ? 16'($urandom) : periods[phase]);
      no_idle = (phase == 3);
      for (int i = 0; i < 12; i++) begin
        r = $urandom_range(99);
        if (r < 60) send_tick();
        else if (r < 72) send_trigger(8'($urandom));
        else if (r < 85) send_item(random_fields(ACT_VOICE));
        else send_item(random_fields(ACT_TABLE));
        if (i == 6) wait_idle();
      end
      no_idle = 0;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SOLO;
    cfg_data = '0;
    errors = 0;
    mismatches = 0;
    no_idle = 0;
    for (int v = 0; v < NV; v++) begin
      m_env_phase[v] = 16'h8000;
      m_env_step[v] = 16'd10;
      m_amp[v] = 8'd255;
      m_wave_phase[v] = 0;
      m_wave_step[v] = 16'd1000;
      m_base_pitch[v] = 16'd500;
      m_mod_depth[v] = 0;
      m_wave_addr[v] = 0;
      m_env_addr[v] = 0;
    end
    m_step_count = 0;
    m_amp_div = 8'd7;
    m_pitch_div = 16'd15;
    m_last_sample = 0;
    m_solo = 8'hff;
    m_running = 1;
    m_period = 16'd4000;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_table_fill();
    test_directed();
    test_config_extremes();
    test_random();

    while (expected_samples.size() != 0) @(negedge clk);
    repeat (TICK_LATENCY) @(negedge clk);
    if (errors == 0) begin
      $display("** wavetable_drum_voice_mixer: PASSED **");
    end else begin
      $display("** wavetable_drum_voice_mixer: FAILED **");
    end
    $finish;
  end
endmodule

// ===== files.f =====
design/wdvm_pkg.sv
design/wavetable_drum_voice_mixer.sv
test/tb.sv
